/* sv/bdq_pkg.sv */
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    FN_PUSH_F = 3'd0,
    FN_PUSH_B = 3'd1,
    FN_POP_F  = 3'd2,
    FN_POP_B  = 3'd3,
    FN_LIST   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_LISTED   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // per-cell command broadcast along the chain
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_F,
    CMD_PUSH_B,
    CMD_POP_F,
    CMD_POP_B,
    CMD_ROT
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] push_value;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

endpackage

/* sv/bdq_cell.sv */
module bdq_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bdq_pkg::cell_ctl_t          ctl,
  input  logic [bdq_pkg::DATA_W-1:0]  left_data,
  input  logic                        left_vld,
  input  logic [bdq_pkg::DATA_W-1:0]  right_data,
  input  logic                        right_vld,
  input  logic [bdq_pkg::DATA_W-1:0]  head_data,
  output logic [bdq_pkg::DATA_W-1:0]  data,
  output logic                        vld,
  output logic                        tail
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              vld_r, vld_nxt;

  always_comb begin
    data_nxt = data_r;
    vld_nxt  = vld_r;
    unique case (ctl.cmd)
      CMD_HOLD: ;
      CMD_PUSH_F: begin
        data_nxt = left_data;
        vld_nxt  = left_vld;
      end
      CMD_PUSH_B: begin
        // first free cell takes the value
        if (!vld_r && left_vld) begin
          data_nxt = ctl.push_value;
          vld_nxt  = 1'b1;
        end
      end
      CMD_POP_F: begin
        data_nxt = right_data;
        vld_nxt  = right_vld;
      end
      CMD_POP_B: begin
        if (vld_r && !right_vld) vld_nxt = 1'b0;
      end
      CMD_ROT: begin
        // rotate left; the tail cell wraps the head around
        if (right_vld) data_nxt = right_data;
        else if (vld_r) data_nxt = head_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign data = data_r;
  assign vld  = vld_r;
  assign tail = vld_r && !right_vld;

endmodule

/* sv/bounded_deque_core.sv */
// Double-ended queue of signed 32-bit values, DEPTH entries deep, built as a
// chain of cells that keeps the entries in order from front (cell 0) to back.
// Push front, push back, pop front and pop back each take one item per cycle
// and give one result. A listing holds off input after the cycle it is taken
// in until its last entry is shown: the chain rotates one cell per result,
// showing the front entry each time, and after a full turn it is back in its
// original order. An empty listing gives one empty result. The result sits in
// an output register; while it waits on a stalled receiver the input is held
// off, and the next item is taken in the cycle the waiting result is taken.
// Func codes 5 to 7 are accepted and dropped without a result.
module bounded_deque_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_func,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bdq_pkg::DATA_W-1:0] out_result_value,
  output logic [2:0]                        out_status,
  output logic                              out_last
);
  import bdq_pkg::*;

  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_vld;
  logic [DEPTH-1:0]  cell_tail;
  logic [DATA_W-1:0] tail_val;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  status_t           out_status_r;
  logic              out_last_r;

  logic              slot_free, in_acc, out_load, full, empty;
  logic [DATA_W-1:0] o_val;
  status_t           o_st;
  logic              o_last;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] l_data, r_data;
      logic              l_vld, r_vld;
      if (gi == 0) begin : g_first
        assign l_data = ctl.push_value;
        assign l_vld  = 1'b1;
      end else begin : g_mid_l
        assign l_data = cell_data[gi-1];
        assign l_vld  = cell_vld[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign r_data = '0;
        assign r_vld  = 1'b0;
      end else begin : g_mid_r
        assign r_data = cell_data[gi+1];
        assign r_vld  = cell_vld[gi+1];
      end
      bdq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .left_data  (l_data),
        .left_vld   (l_vld),
        .right_data (r_data),
        .right_vld  (r_vld),
        .head_data  (cell_data[0]),
        .data       (cell_data[gi]),
        .vld        (cell_vld[gi]),
        .tail       (cell_tail[gi])
      );
    end
  endgenerate

  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_tail[i]) tail_val = tail_val | cell_data[i];
    end
  end

  assign full      = cell_vld[DEPTH-1];
  assign empty     = !cell_vld[0];
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    ctl.cmd        = CMD_HOLD;
    ctl.push_value = in_push_value;
    out_load       = 1'b0;
    o_val          = '0;
    o_st           = ST_EMPTY;
    o_last         = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_func) inside
            FN_PUSH_F, FN_PUSH_B: begin
              out_load = 1'b1;
              if (full) begin
                o_st = ST_FULL;
              end else begin
                ctl.cmd = (in_func == FN_PUSH_F) ? CMD_PUSH_F : CMD_PUSH_B;
                cnt_nxt = cnt_r + CNT_W'(1);
                o_st    = ST_INSERTED;
              end
            end
            FN_POP_F, FN_POP_B: begin
              out_load = 1'b1;
              if (!empty) begin
                ctl.cmd = (in_func == FN_POP_F) ? CMD_POP_F : CMD_POP_B;
                o_val   = (in_func == FN_POP_F) ? cell_data[0] : tail_val;
                cnt_nxt = cnt_r - CNT_W'(1);
                o_st    = ST_REMOVED;
              end
            end
            FN_LIST: begin
              if (empty) begin
                out_load = 1'b1;
              end else begin
                state_nxt = S_LIST;
                rem_nxt   = cnt_r;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_load = 1'b1;
          o_val    = cell_data[0];
          o_st     = ST_LISTED;
          o_last   = (rem_r == CNT_W'(1));
          ctl.cmd  = CMD_ROT;
          rem_nxt  = rem_r - CNT_W'(1);
          if (o_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= o_val;
      out_status_r <= o_st;
      out_last_r   <= o_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  // live cells always form an unbroken run from the front
  a_vld_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("gap in live cells");

  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(cell_vld)))
    else $error("entry count out of step with cells");

  a_list_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIST |-> (rem_r != '0) && (rem_r <= cnt_r))
    else $error("listing counter out of range");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) && slot_free && (rem_r == CNT_W'(1)) |=>
      (state_r == S_IDLE) && out_valid_r && out_last_r)
    else $error("listing did not close with a last item");

endmodule

/* dv/tb_bounded_deque_core.sv */
`timescale 1ns / 100ps

module tb_bounded_deque_core;
  import bdq_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int RAND_ITEMS  = 360;
  localparam int PHASE_ITEMS = 40;

  localparam int RX_FREE    = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_HEAVY   = 3;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     last;
  } deque_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               in_func;
  logic signed [DATA_W-1:0] in_push_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_result_value;
  logic [2:0]               out_status;
  logic                     out_last;

  // predictor state
  logic signed [DATA_W-1:0] slot [DEPTH];
  int                       head_idx;
  int                       fill;
  deque_result_t            pending_results [$];

  int       errors;
  int       rx_mode;
  logic [7:0] rx_pat_cfg;
  logic [7:0] rx_tick;
  int       hold_gen;
  int       hold_seen;
  int       hold_cnt;
  int       burst_left;

  bounded_deque_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void add_result(logic signed [DATA_W-1:0] v, status_t st, logic lst);
    deque_result_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void deque_apply(logic [2:0] fn, logic signed [DATA_W-1:0] v);
    int pos;
    case (fn)
      FN_PUSH_F, FN_PUSH_B: begin
        if (fill >= DEPTH) begin
          add_result('0, ST_FULL, 1'b1);
        end else begin
          if (fn == FN_PUSH_F) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            slot[head_idx] = v;
          end else begin
            slot[(head_idx + fill) % DEPTH] = v;
          end
          fill++;
          add_result('0, ST_INSERTED, 1'b1);
        end
      end
      FN_POP_F, FN_POP_B: begin
        if (fill == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (fn == FN_POP_F) begin
            add_result(slot[head_idx], ST_REMOVED, 1'b1);
            head_idx = (head_idx + 1) % DEPTH;
          end else begin
            pos = (head_idx + fill - 1) % DEPTH;
            add_result(slot[pos], ST_REMOVED, 1'b1);
          end
          fill--;
        end
      end
      FN_LIST: begin
        if (fill == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++)
            add_result(slot[(head_idx + i) % DEPTH], ST_LISTED, i == fill - 1);
        end
      end
      default: ; // unused codes: dropped, no result
    endcase
  endfunction

  // Leaves valid high on return so a following item goes out back to back.
  task automatic send_item(logic [2:0] fn, logic signed [DATA_W-1:0] v);
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_push_value <= v;
    do @(posedge clk); while (in_stall);
    deque_apply(fn, v);
  endtask

  task automatic go_idle(int n);
    if (n > 0) begin
      in_valid      <= 1'b0;
      in_func       <= 3'($urandom);
      in_push_value <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // burst/gap shaping for the random part
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 10);
      go_idle($urandom_range(1, 6));
    end
  endtask

  // result check
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: value %0d status %0d last %0d",
               out_result_value, out_status, out_last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", want.value, out_result_value);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // result-side stall generator; a bump of hold_gen starts a long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_cnt  <= 0;
      rx_tick   <= '0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (hold_gen != hold_seen) begin
        hold_seen <= hold_gen;
        hold_cnt  <= HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:    out_stall <= 1'b0;
          RX_RANDOM:  out_stall <= $urandom_range(0, 3) == 0;
          RX_PATTERN: out_stall <= rx_pat_cfg[rx_tick[2:0]];
          RX_HEAVY:   out_stall <= $urandom_range(0, 9) < 7;
          default:    out_stall <= 1'b0;
        endcase
      end
    end
  end

  task automatic test_empty_ops();
    rx_mode = RX_FREE;
    send_item(FN_POP_F, pick_value());
    send_item(FN_POP_B, pick_value());
    send_item(FN_LIST, '0);
    for (int c = int'(FN_LIST) + 1; c < 8; c++)
      send_item(3'(c), $urandom);
    go_idle(2);
  endtask

  task automatic test_single_entry();
    rx_mode = RX_RANDOM;
    // the only entry leaves at the front, then at the back
    send_item(FN_PUSH_F, 32'sh7fff_ffff);
    send_item(FN_POP_F, '0);
    send_item(FN_PUSH_B, 32'sh8000_0000);
    send_item(FN_POP_B, '0);
    send_item(FN_LIST, '0);
    send_item(FN_PUSH_F, '0);
    send_item(FN_PUSH_B, -32'sd1);
    send_item(FN_PUSH_F, 32'sh8000_0000);
    send_item(FN_PUSH_B, 32'sh7fff_ffff);
    send_item(FN_LIST, '0);
    send_item(FN_POP_B, '0);
    send_item(FN_POP_F, '0);
    send_item(FN_POP_B, '0);
    send_item(FN_POP_F, '0);
    send_item(FN_POP_F, '0);
    go_idle(3);
  endtask

  // receiver holds off at the start of a run of pushes that goes past full
  task automatic test_fill_under_hold();
    rx_mode = RX_FREE;
    hold_gen <= hold_gen + 1;
    for (int i = 0; i < DEPTH + 4; i++)
      send_item($urandom_range(0, 1) ? FN_PUSH_F : FN_PUSH_B, pick_value());
    send_item(FN_LIST, $urandom);
    rx_mode = RX_PATTERN;
    rx_pat_cfg = 8'b0110_0101;
    for (int i = 0; i < DEPTH + 1; i++)
      send_item($urandom_range(0, 1) ? FN_POP_F : FN_POP_B, $urandom);
    go_idle(2);
  endtask

  task automatic test_random_ops();
    int  sent;
    int  phase;
    int  r;
    bit  fill_up;
    logic [2:0] fn;
    sent       = 0;
    phase      = 0;
    burst_left = 0;
    while (sent < RAND_ITEMS) begin
      if (sent >= (phase + 1) * PHASE_ITEMS) begin
        phase++;
        rx_mode    = phase % 4;
        rx_pat_cfg = $urandom;
      end
      fill_up = (phase % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 3)
        fn = 3'($urandom_range(int'(FN_LIST) + 1, 7));
      else if (r < 11)
        fn = FN_LIST;
      else if (r < (fill_up ? 71 : 41))
        fn = $urandom_range(0, 1) ? FN_PUSH_F : FN_PUSH_B;
      else
        fn = $urandom_range(0, 1) ? FN_POP_F : FN_POP_B;
      send_item(fn, pick_value());
      if (fn <= FN_LIST)
        sent++;
      pace_sender();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= '0;
    in_push_value <= '0;
    errors     = 0;
    rx_mode    = RX_FREE;
    rx_pat_cfg = '0;
    hold_gen   = 0;
    head_idx   = 0;
    fill       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ops();
    test_single_entry();
    test_fill_under_hold();
    test_random_ops();

    go_idle(1);
    rx_mode = RX_RANDOM;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
